[design/fqsd_pkg.sv]
package fqsd_pkg;

	localparam int unsigned MODE_W    = 3;
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned KEY_W     = 15;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned OCC_W     = 5;
	localparam int unsigned DEPTH_DEF = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ  = 3'd0,
		MODE_DEQ  = 3'd1,
		MODE_PEEK = 3'd2,
		MODE_SRCH = 3'd3,
		MODE_DEL  = 3'd4,
		MODE_CLR  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_NEG   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

endpackage

[design/fqsd_req_if.sv]
interface fqsd_req_if;
	logic                                valid;
	logic                                ready;
	logic [fqsd_pkg::MODE_W-1:0]         mode;
	logic signed [fqsd_pkg::VALUE_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

[design/fqsd_rsp_if.sv]
interface fqsd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fqsd_pkg::STATUS_W-1:0] status;
	logic [fqsd_pkg::KEY_W-1:0]    data_out;
	logic                          found;
	logic                          is_empty;
	logic [fqsd_pkg::OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output data_out, output found,
		output is_empty, output occupancy, input ready);
	modport sink (input valid, input status, input data_out, input found,
		input is_empty, input occupancy, output ready);
endinterface

[design/fqsd_mem.sv]
module fqsd_mem #(
	parameter int unsigned DEPTH = fqsd_pkg::DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [fqsd_pkg::KEY_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [fqsd_pkg::KEY_W-1:0] rdata
);
	import fqsd_pkg::*;

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/fqsd_ctrl.sv]
module fqsd_ctrl #(
	parameter int unsigned DEPTH = fqsd_pkg::DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fqsd_req_if.sink                   req,
	fqsd_rsp_if.source                 rsp,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [fqsd_pkg::KEY_W-1:0] mem_wdata,
	output logic [AW-1:0]              mem_raddr,
	input  logic [fqsd_pkg::KEY_W-1:0] mem_rdata
);
	import fqsd_pkg::*;

	localparam logic [CW-1:0]    ONE_C    = CW'(1);
	localparam logic [CW-1:0]    TWO_C    = CW'(2);
	localparam logic [CW-1:0]    FULL_C   = CW'(DEPTH);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	// Ring position of the entry that lies rel places after the oldest one.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
		input logic [CW-1:0] rel);
		logic [AW:0] s;
		s = {1'b0, head} + (AW+1)'(rel);
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	state_t           st_q, st_d;
	logic [AW-1:0]    head_q, head_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    idx_q, idx_d;
	mode_t            mode_q, mode_d;
	logic [KEY_W-1:0] key_q, key_d;

	logic             in_ready, accept, negative;
	logic [KEY_W-1:0] key;
	logic             done;
	status_t          r_status;
	logic [KEY_W-1:0] r_data;
	logic             r_found;
	logic [CW-1:0]    r_count;

	logic             rsp_valid_q;
	status_t          status_q;
	logic [KEY_W-1:0] data_q;
	logic             found_q, empty_q;
	logic [OCC_W-1:0] occ_q;

	assign in_ready  = (st_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req.ready = in_ready;
	assign accept    = req.valid && in_ready;
	assign negative  = req.value[VALUE_W-1];
	assign key       = req.value[KEY_W-1:0];

	always_comb begin
		st_d      = st_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		mode_d    = mode_q;
		key_d     = key_q;
		done      = 1'b0;
		r_status  = ST_OK;
		r_data    = '0;
		r_found   = 1'b0;
		r_count   = count_q;
		mem_we    = 1'b0;
		mem_waddr = phys(head_q, count_q);
		mem_wdata = key;
		mem_raddr = head_q;
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					mode_d = mode_t'(req.mode);
					key_d  = key;
					idx_d  = '0;
					case (mode_t'(req.mode))
						MODE_ENQ: begin
							done = 1'b1;
							if (negative) begin
								r_status = ST_NEG;
							end else if (count_q == FULL_C) begin
								r_status = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + ONE_C;
								r_count = count_d;
							end
						end
						MODE_DEQ, MODE_PEEK: begin
							if (count_q == '0) begin
								done     = 1'b1;
								r_status = ST_EMPTY;
							end else begin
								st_d = S_READ;
							end
						end
						MODE_SRCH, MODE_DEL: begin
							if (negative || count_q == '0) begin
								done = 1'b1;
							end else begin
								st_d = S_SCAN;
							end
						end
						MODE_CLR: begin
							done    = 1'b1;
							count_d = '0;
							head_d  = '0;
							r_count = '0;
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				done   = 1'b1;
				r_data = mem_rdata;
				st_d   = S_IDLE;
				if (mode_q == MODE_DEQ) begin
					head_d  = phys(head_q, ONE_C);
					count_d = count_q - ONE_C;
					r_count = count_d;
				end
			end
			S_SCAN: begin
				mem_raddr = phys(head_q, idx_q + ONE_C);
				if (mem_rdata == key_q) begin
					if (mode_q == MODE_DEL) begin
						st_d = S_SHIFT;
					end else begin
						done    = 1'b1;
						r_found = 1'b1;
						st_d    = S_IDLE;
					end
				end else if (idx_q + ONE_C == count_q) begin
					done = 1'b1;
					st_d = S_IDLE;
				end else begin
					idx_d = idx_q + ONE_C;
				end
			end
			S_SHIFT: begin
				if (idx_q + ONE_C < count_q) begin
					mem_we    = 1'b1;
					mem_waddr = phys(head_q, idx_q);
					mem_wdata = mem_rdata;
					mem_raddr = phys(head_q, idx_q + TWO_C);
					idx_d     = idx_q + ONE_C;
				end else begin
					count_d = count_q - ONE_C;
					r_count = count_d;
					r_found = 1'b1;
					done    = 1'b1;
					st_d    = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		mode_q <= mode_d;
		key_q  <= key_d;
		if (done) begin
			status_q <= r_status;
			data_q   <= r_data;
			found_q  <= r_found;
			empty_q  <= (r_count == '0);
			occ_q    <= OCC_W'(r_count);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.data_out  = data_q;
	assign rsp.found     = found_q;
	assign rsp.is_empty  = empty_q;
	assign rsp.occupancy = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("entry count exceeds the queue depth");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !in_ready)
		else $error("request accepted while an operation is in progress");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == ST_FULL) |-> (occ_q == FULL_OCC))
		else $error("full status reported with the queue not full");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && st_q != S_IDLE) |=> (st_q == S_IDLE && rsp_valid_q))
		else $error("finished operation did not return to idle with a response");

endmodule

[design/fifo_queue_search_delete_unit.sv]
// Enqueue, clear, rejected and empty requests give a registered response in the cycle after acceptance.
// Dequeue and peek pass through the read state, as the oldest entry is read from the ring memory first.
// Search walks the entries one per cycle until it finds the key or has checked the newest entry.
// A matching delete then moves the later entries down, one per cycle.
// A new request is taken in the cycle its predecessor's response is shown, if the sink takes it.
// Reset clears the fill count, ring head and response valid; the entries stay as they were.
module fifo_queue_search_delete_unit #(
	parameter int unsigned DEPTH = fqsd_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fqsd_req_if.sink   req,
	fqsd_rsp_if.source rsp
);
	import fqsd_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [KEY_W-1:0] mem_rdata;

	fqsd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	fqsd_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
